[hdl/ecef_ae_pkg.sv]
// Shared constants, tables and helpers for the ECEF to azimuth/elevation pipeline.
`default_nettype none
package ecef_ae_pkg;

   localparam int ANGLE_BITS_DEF     = 16;
   localparam int TRIG_FRAC_BITS_DEF = 18;

   // register indexes of the configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_RCV_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RCV_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RCV_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RCV_LAT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RCV_LON = 3'd4;

   localparam int RCV_W   = 24;
   localparam int SAT_W   = 26;
   localparam int ANG_W   = 16;
   localparam int DIFF_W  = 27;   // satellite minus receiver
   localparam int NEU_W   = 33;   // north/east/up, 4 fraction bits of a metre
   localparam int NEU_FRAC = 4;
   localparam int VEC_W   = NEU_W + 1;
   localparam int TURN_W  = 32;   // internal angle, binary fraction of a turn

   localparam longint GAIN_Q31 = 64'd1304065748;
   localparam int     GAIN_W   = 24;
   localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10187563;

   localparam logic [TURN_W-1:0] ATAN_TURN [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
      32'd1,         32'd0
   };

   // start value of the rotation CORDIC: inverse gain rounded to f fraction bits
   function automatic logic [31:0] cordic_x0(int f);
      longint g;
      g = (GAIN_Q31 + (longint'(1) << (30 - f))) >>> (31 - f);
      return 32'(g);
   endfunction

endpackage
`default_nettype wire

[hdl/ecef_ae_ctrl.sv]
// Valid bits and per-stage load enables of the pipeline.
`default_nettype none
module ecef_ae_ctrl #(
   parameter int DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [DEPTH-1:0]      en
);

   logic [DEPTH-1:0] v_ff;

   // a stage loads when the output is taken or when it or any stage after it is empty
   for (genvar i = 0; i < DEPTH; i++) begin : g_en
      assign en[i] = out_ready | ~(&v_ff[DEPTH-1:i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[DEPTH-1];

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones(v_ff) == $past($countones(v_ff))
               + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)))
      else $error("item count in pipeline not conserved");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&v_ff && !out_ready) |-> !in_ready)
      else $error("item taken while pipeline full and stalled");
   a_tail_free: assert property (@(posedge clock) disable iff (reset)
      !v_ff[DEPTH-1] |-> (in_ready && (&en)))
      else $error("stage held while output stage empty");
`endif

endmodule
`default_nettype wire

[hdl/ecef_ae_rot.sv]
// Pipelined rotation CORDIC: sine and cosine of a 16-bit turn angle.
`default_nettype none
module ecef_ae_rot #(
   parameter int TRIG_FRAC_BITS = ecef_ae_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic [TRIG_FRAC_BITS+1:0]         en,
   input  wire logic [ecef_ae_pkg::ANG_W-1:0]     angle,
   output logic signed [TRIG_FRAC_BITS+1:0]       sin_out,
   output logic signed [TRIG_FRAC_BITS+1:0]       cos_out
);
   import ecef_ae_pkg::*;

   localparam int F  = TRIG_FRAC_BITS;
   localparam int TW = F + 2;
   localparam int ZW = TURN_W + 1;
   localparam logic signed [TW-1:0] X0 = TW'(cordic_x0(F));

   logic signed [TW-1:0] x_ff [F+1];
   logic signed [TW-1:0] y_ff [F+1];
   logic signed [ZW-1:0] z_ff [F+1];
   logic                 flip_ff [F+1];
   logic [TURN_W-1:0]    ph_in;
   logic                 flip_in;

   // fold the left half-plane onto the right one and negate at the end
   always_comb begin
      ph_in   = {angle, {(TURN_W-ANG_W){1'b0}}};
      flip_in = ph_in[TURN_W-1] ^ ph_in[TURN_W-2];
      if (flip_in) begin
         ph_in[TURN_W-1] = ~ph_in[TURN_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0]    <= X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= {ph_in[TURN_W-1], ph_in};
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar k = 0; k < F; k++) begin : g_step
      localparam logic signed [ZW-1:0] A_K = {1'b0, ATAN_TURN[k]};
      logic signed [TW-1:0] xs, ys;
      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (en[k+1]) begin
            if (z_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] - ys;
               y_ff[k+1] <= y_ff[k] + xs;
               z_ff[k+1] <= z_ff[k] - A_K;
            end else begin
               x_ff[k+1] <= x_ff[k] + ys;
               y_ff[k+1] <= y_ff[k] - xs;
               z_ff[k+1] <= z_ff[k] + A_K;
            end
            flip_ff[k+1] <= flip_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[F+1]) begin
         cos_out <= flip_ff[F] ? -x_ff[F] : x_ff[F];
         sin_out <= flip_ff[F] ? -y_ff[F] : y_ff[F];
      end
   end

endmodule
`default_nettype wire

[hdl/ecef_ae_vec.sv]
// Pipelined vectoring CORDIC: turn angle and scaled length of (x, y).
`default_nettype none
module ecef_ae_vec #(
   parameter int STEPS  = ecef_ae_pkg::TRIG_FRAC_BITS_DEF,
   parameter int SIDE_W = 16
) (
   input  wire logic                                clock,
   input  wire logic [STEPS:0]                      en,
   input  wire logic signed [ecef_ae_pkg::VEC_W-1:0] x_in,
   input  wire logic signed [ecef_ae_pkg::VEC_W-1:0] y_in,
   input  wire logic [SIDE_W-1:0]                   side_in,
   output logic signed [ecef_ae_pkg::VEC_W-1:0]     mag_out,
   output logic [ecef_ae_pkg::TURN_W-1:0]           ang_out,
   output logic                                     zero_out,
   output logic [SIDE_W-1:0]                        side_out
);
   import ecef_ae_pkg::*;

   logic signed [VEC_W-1:0] x_ff [STEPS+1];
   logic signed [VEC_W-1:0] y_ff [STEPS+1];
   logic [TURN_W-1:0]       z_ff [STEPS+1];
   logic                    zero_ff [STEPS+1];
   logic [SIDE_W-1:0]       side_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         side_ff[0] <= side_in;
         // start from the right half-plane
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= {1'b1, {(TURN_W-1){1'b0}}};
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic signed [VEC_W-1:0] xs, ys;
      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (en[k+1]) begin
            if (y_ff[k] > 0) begin
               x_ff[k+1] <= x_ff[k] + ys;
               y_ff[k+1] <= y_ff[k] - xs;
               z_ff[k+1] <= z_ff[k] + ATAN_TURN[k];
            end else begin
               x_ff[k+1] <= x_ff[k] - ys;
               y_ff[k+1] <= y_ff[k] + xs;
               z_ff[k+1] <= z_ff[k] - ATAN_TURN[k];
            end
            zero_ff[k+1] <= zero_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign mag_out  = x_ff[STEPS];
   assign ang_out  = z_ff[STEPS];
   assign zero_out = zero_ff[STEPS];
   assign side_out = side_ff[STEPS];

endmodule
`default_nettype wire

[hdl/ecef_to_azimuth_elevation.sv]
// Top level: satellite ECEF position to azimuth and elevation seen from the receiver.
//
//   channel  direction  contents
//   req_     in         tdata = sat_x[25:0], sat_y[51:26], sat_z[77:52], zero pad
//   rsp_     out        tdata = elevation[15:0], azimuth[31:16]
//   csr_     in         write enable, register index, 24-bit write data
//
// One item enters per cycle unless the pipeline is full and the output stalled; the
// pipeline has 3*TRIG_FRAC_BITS+10 stages, set by the sine/cosine CORDIC and the two
// vectoring CORDICs in series.
// Each stage holds only while every stage after it is full and the output is
// stalled, so bubbles close up and an item enters while a result waits.
// Reset clears the valid bits and the receiver registers.
`default_nettype none
module ecef_to_azimuth_elevation #(
   parameter int ANGLE_BITS     = ecef_ae_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_FRAC_BITS = ecef_ae_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [79:0]                          req_tdata,  // sat_x, sat_y, sat_z
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [31:0]                               rsp_tdata,  // elevation, azimuth
   input  wire logic                                 csr_we,
   input  wire logic [ecef_ae_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ecef_ae_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ecef_ae_pkg::*;

   localparam int F       = TRIG_FRAC_BITS;
   localparam int TW      = F + 2;
   localparam int PW      = TW + DIFF_W;
   localparam int SW      = PW + 2;
   localparam int SH      = F - NEU_FRAC;
   localparam int HSPLIT  = 17;
   localparam int HH_W    = VEC_W - HSPLIT;
   localparam int HLP_W   = HSPLIT + GAIN_W;
   localparam int HHP_W   = HH_W + GAIN_W;
   localparam int HS_W    = HHP_W + HSPLIT + 1;

   localparam int ST_MUL  = F + 2;
   localparam int ST_PRD  = F + 3;
   localparam int ST_NEU  = F + 4;
   localparam int ST_AZV  = F + 5;
   localparam int ST_HMUL = 2 * F + 6;
   localparam int ST_HSUM = 2 * F + 7;
   localparam int ST_ELV  = 2 * F + 8;
   localparam int ST_OUT  = 3 * F + 9;
   localparam int DEPTH   = 3 * F + 10;

   localparam logic signed [2*TW-1:0] MQ_RND  = (2*TW)'(1) << (F - 1);
   localparam logic signed [SW-1:0]   NEU_RND = SW'(1) << (SH - 1);
   localparam logic [HS_W-1:0]        HK_RND  = HS_W'(1) << (GAIN_W - 1);
   localparam logic [TURN_W-1:0]      AZ_RND  = TURN_W'(1) << (31 - ANGLE_BITS);
   localparam logic signed [TURN_W:0] EL_RND  = (TURN_W+1)'(1) << (31 - ANGLE_BITS);

   // configuration registers
   logic signed [RCV_W-1:0] rcv_x_ff, rcv_y_ff, rcv_z_ff;
   logic [ANG_W-1:0]        rcv_lat_ff, rcv_lon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rcv_x_ff   <= '0;
         rcv_y_ff   <= '0;
         rcv_z_ff   <= '0;
         rcv_lat_ff <= '0;
         rcv_lon_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RCV_X:   rcv_x_ff   <= csr_wdata;
            CSR_RCV_Y:   rcv_y_ff   <= csr_wdata;
            CSR_RCV_Z:   rcv_z_ff   <= csr_wdata;
            CSR_RCV_LAT: rcv_lat_ff <= csr_wdata[ANG_W-1:0];
            CSR_RCV_LON: rcv_lon_ff <= csr_wdata[ANG_W-1:0];
            default: ;
         endcase
      end
   end

   logic [DEPTH-1:0] stage_en;

   ecef_ae_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .en        (stage_en)
   );

   // difference vector, carried alongside the sine/cosine CORDIC
   logic signed [DIFF_W-1:0] dx_ff [F+2];
   logic signed [DIFF_W-1:0] dy_ff [F+2];
   logic signed [DIFF_W-1:0] dz_ff [F+2];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dx_ff[0] <= DIFF_W'($signed(req_tdata[SAT_W-1:0])) - DIFF_W'(rcv_x_ff);
         dy_ff[0] <= DIFF_W'($signed(req_tdata[2*SAT_W-1:SAT_W])) - DIFF_W'(rcv_y_ff);
         dz_ff[0] <= DIFF_W'($signed(req_tdata[3*SAT_W-1:2*SAT_W])) - DIFF_W'(rcv_z_ff);
      end
   end

   for (genvar k = 1; k < F + 2; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            dx_ff[k] <= dx_ff[k-1];
            dy_ff[k] <= dy_ff[k-1];
            dz_ff[k] <= dz_ff[k-1];
         end
      end
   end

   logic signed [TW-1:0] slat, clat, slon, clon;

   ecef_ae_rot #(.TRIG_FRAC_BITS(F)) u_rot_lat (
      .clock   (clock),
      .en      (stage_en[F+1:0]),
      .angle   (rcv_lat_ff),
      .sin_out (slat),
      .cos_out (clat)
   );

   ecef_ae_rot #(.TRIG_FRAC_BITS(F)) u_rot_lon (
      .clock   (clock),
      .en      (stage_en[F+1:0]),
      .angle   (rcv_lon_ff),
      .sin_out (slon),
      .cos_out (clon)
   );

   // rotation coefficients: trig products rounded back to F fraction bits
   logic signed [2*TW-1:0] m_a, m_b, m_c, m_d;
   logic signed [TW-1:0]   ca_ff, cb_ff, cc_ff, cd_ff;
   logic signed [TW-1:0]   slat_ff, clat_ff, slon_ff, clon_ff;
   logic signed [DIFF_W-1:0] dxm_ff, dym_ff, dzm_ff;

   always_comb begin
      m_a = (slat * clon + MQ_RND) >>> F;
      m_b = (slat * slon + MQ_RND) >>> F;
      m_c = (clat * clon + MQ_RND) >>> F;
      m_d = (clat * slon + MQ_RND) >>> F;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_MUL]) begin
         ca_ff   <= TW'(m_a);
         cb_ff   <= TW'(m_b);
         cc_ff   <= TW'(m_c);
         cd_ff   <= TW'(m_d);
         slat_ff <= slat;
         clat_ff <= clat;
         slon_ff <= slon;
         clon_ff <= clon;
         dxm_ff  <= dx_ff[F+1];
         dym_ff  <= dy_ff[F+1];
         dzm_ff  <= dz_ff[F+1];
      end
   end

   logic signed [PW-1:0] pn0_ff, pn1_ff, pn2_ff, pe0_ff, pe1_ff, pu0_ff, pu1_ff, pu2_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_PRD]) begin
         pn0_ff <= ca_ff * dxm_ff;
         pn1_ff <= cb_ff * dym_ff;
         pn2_ff <= clat_ff * dzm_ff;
         pe0_ff <= slon_ff * dxm_ff;
         pe1_ff <= clon_ff * dym_ff;
         pu0_ff <= cc_ff * dxm_ff;
         pu1_ff <= cd_ff * dym_ff;
         pu2_ff <= slat_ff * dzm_ff;
      end
   end

   logic signed [SW-1:0]    sn, se, su, rn, re, ru;
   logic signed [NEU_W-1:0] n_ff, e_ff, u_ff;

   always_comb begin
      sn = SW'(pn2_ff) - SW'(pn0_ff) - SW'(pn1_ff);
      se = SW'(pe1_ff) - SW'(pe0_ff);
      su = SW'(pu0_ff) + SW'(pu1_ff) + SW'(pu2_ff);
      rn = (sn + NEU_RND) >>> SH;
      re = (se + NEU_RND) >>> SH;
      ru = (su + NEU_RND) >>> SH;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_NEU]) begin
         n_ff <= NEU_W'(rn);
         e_ff <= NEU_W'(re);
         u_ff <= NEU_W'(ru);
      end
   end

   // azimuth = atan2(east, north); the length feeds the elevation
   logic signed [VEC_W-1:0] h_mag;
   logic [TURN_W-1:0]       az_ang;
   logic                    az_zero;
   logic [NEU_W-1:0]        u_azv;

   ecef_ae_vec #(.STEPS(F), .SIDE_W(NEU_W)) u_vec_az (
      .clock    (clock),
      .en       (stage_en[ST_AZV+F:ST_AZV]),
      .x_in     (VEC_W'(n_ff)),
      .y_in     (VEC_W'(e_ff)),
      .side_in  (u_ff),
      .mag_out  (h_mag),
      .ang_out  (az_ang),
      .zero_out (az_zero),
      .side_out (u_azv)
   );

   logic [TURN_W-1:0]     az_sum;
   logic [HLP_W-1:0]      hlp_ff;
   logic [HHP_W-1:0]      hhp_ff;
   logic [ANG_W-1:0]      az_h_ff, az_k_ff;
   logic [NEU_W-1:0]      u_h_ff, u_k_ff;
   logic signed [VEC_W-1:0] hk_ff;
   logic [HS_W-1:0]       hk_sum;

   assign az_sum = az_ang + AZ_RND;

   // drop the CORDIC gain from the length, split to keep the multipliers narrow
   always_ff @(posedge clock) begin
      if (stage_en[ST_HMUL]) begin
         hlp_ff  <= HLP_W'(h_mag[HSPLIT-1:0]) * HLP_W'(GAIN_Q24);
         hhp_ff  <= HHP_W'(h_mag[VEC_W-1:HSPLIT]) * HHP_W'(GAIN_Q24);
         az_h_ff <= az_zero ? '0 : ANG_W'(az_sum >> (TURN_W - ANGLE_BITS));
         u_h_ff  <= u_azv;
      end
   end

   assign hk_sum = {1'b0, hhp_ff, {HSPLIT{1'b0}}} + HS_W'(hlp_ff) + HK_RND;

   always_ff @(posedge clock) begin
      if (stage_en[ST_HSUM]) begin
         hk_ff   <= VEC_W'(hk_sum >> GAIN_W);
         az_k_ff <= az_h_ff;
         u_k_ff  <= u_h_ff;
      end
   end

   // elevation = atan2(up, horizontal length)
   logic signed [VEC_W-1:0] el_mag;
   logic [TURN_W-1:0]       el_ang;
   logic                    el_zero;
   logic [ANG_W-1:0]        az_elv;

   ecef_ae_vec #(.STEPS(F), .SIDE_W(ANG_W)) u_vec_el (
      .clock    (clock),
      .en       (stage_en[ST_ELV+F:ST_ELV]),
      .x_in     (hk_ff),
      .y_in     (VEC_W'($signed(u_k_ff))),
      .side_in  (az_k_ff),
      .mag_out  (el_mag),
      .ang_out  (el_ang),
      .zero_out (el_zero),
      .side_out (az_elv)
   );

   logic signed [TURN_W:0] el_sum, el_shift;
   logic [ANG_W-1:0]       el_ff, az_ff;

   always_comb begin
      el_sum   = $signed({el_ang[TURN_W-1], el_ang}) + EL_RND;
      el_shift = el_sum >>> (TURN_W - ANGLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         // zero vector, or a length that rounds to zero with no up part
         el_ff <= (el_zero || el_mag == '0 && el_zero) ? '0 : el_shift[ANG_W-1:0];
         az_ff <= az_elv;
      end
   end

   assign rsp_tdata = {az_ff, el_ff};

endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for the satellite ECEF to azimuth/elevation pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import ecef_ae_pkg::*;

   localparam int TF = TRIG_FRAC_BITS_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd5;

   // Predicts azimuth and elevation per satellite position and checks results in order.
   class look_angle_board;
      logic [RCV_W-1:0] rcv_x, rcv_y, rcv_z;
      logic [ANG_W-1:0] rcv_lat, rcv_lon;
      logic [ANG_W-1:0] el_q[$], az_q[$];
      int errors;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_RCV_X:   rcv_x = v;
            CSR_RCV_Y:   rcv_y = v;
            CSR_RCV_Z:   rcv_z = v;
            CSR_RCV_LAT: rcv_lat = v[15:0];
            CSR_RCV_LON: rcv_lon = v[15:0];
            default: ;
         endcase
      endfunction

      function longint mul_trig(longint a, longint b);
         return (a * b + (longint'(1) << (TF - 1))) >>> TF;
      endfunction

      function longint to_neu(longint v);
         return (v + (longint'(1) << (TF - NEU_FRAC - 1))) >>> (TF - NEU_FRAC);
      endfunction

      function void sin_cos(logic [15:0] a, output longint s, output longint c);
         logic [31:0] ph;
         bit flip;
         longint x, y, z, xs, ys;
         ph = {a, 16'h0};
         flip = 0;
         if (ph >= 32'h4000_0000 && ph < 32'hC000_0000) begin
            ph = ph - 32'h8000_0000;
            flip = 1;
         end
         z = longint'(signed'(ph));
         x = (GAIN_Q31 + (longint'(1) << (30 - TF))) >>> (31 - TF);
         y = 0;
         for (int i = 0; i < TF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - longint'(ATAN_TURN[i]);
            end else begin
               x = x + ys; y = y - xs; z = z + longint'(ATAN_TURN[i]);
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function logic [31:0] vec_turn(longint x, longint y, output longint mag);
         logic [31:0] z;
         longint xs, ys;
         z = 0;
         if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
         end
         for (int i = 0; i < TF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys; y = y - xs; z = z + ATAN_TURN[i];
            end else begin
               x = x - ys; y = y + xs; z = z - ATAN_TURN[i];
            end
         end
         mag = x;
         return z;
      endfunction

      function void note_position(logic [SAT_W-1:0] sx, sy, sz);
         longint dx, dy, dz, slat, clat, slon, clon, n, e, u, h, hk, dummy, s;
         logic [31:0] az32, t;
         logic [15:0] az, el;
         dx = longint'(signed'(sx)) - longint'(signed'(rcv_x));
         dy = longint'(signed'(sy)) - longint'(signed'(rcv_y));
         dz = longint'(signed'(sz)) - longint'(signed'(rcv_z));
         sin_cos(rcv_lat, slat, clat);
         sin_cos(rcv_lon, slon, clon);
         n = to_neu(-mul_trig(slat, clon) * dx - mul_trig(slat, slon) * dy + clat * dz);
         e = to_neu(-slon * dx + clon * dy);
         u = to_neu(mul_trig(clat, clon) * dx + mul_trig(clat, slon) * dy + slat * dz);
         az = 0;
         if (n == 0 && e == 0) begin
            h = 0;
         end else begin
            az32 = vec_turn(n, e, h);
            t = az32 + 32'h8000;
            az = t[31:16];
         end
         hk = (h * longint'(GAIN_Q24) + (longint'(1) << 23)) >>> 24;
         el = 0;
         if (hk != 0 || u != 0) begin
            s = longint'(signed'(vec_turn(hk, u, dummy)));
            s = (s + 32768) >>> 16;
            el = s[15:0];
         end
         el_q.push_back(el);
         az_q.push_back(az);
      endfunction

      function void check_result(logic [31:0] d);
         logic [15:0] el, az;
         if (el_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
         end
         el = el_q.pop_front();
         az = az_q.pop_front();
         if (d[15:0] !== el) begin
            $display("%0t: elevation expected %h actual %h", $time, el, d[15:0]);
            errors++;
         end
         if (d[31:16] !== az) begin
            $display("%0t: azimuth expected %h actual %h", $time, az, d[31:16]);
            errors++;
         end
      endfunction

      function int pending();
         return el_q.size();
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [79:0] req_tdata = '0;  // sat_x, sat_y, sat_z, zero pad
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;       // elevation, azimuth
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   look_angle_board board = new();
   int burst_left = 0;
   int stall_left = 0;
   bit stall_on = 0;

   ecef_to_azimuth_elevation i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: alternate random stall spells with ready spells
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if (stall_left == 0) begin
         stall_on <= $urandom_range(0, 2) == 0;
         stall_left <= $urandom_range(1, 30);
         rsp_tready <= 1;
      end else begin
         stall_left <= stall_left - 1;
         rsp_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   task automatic send_position(logic [SAT_W-1:0] sx, sy, sz);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tdata <= {2'b00, sz, sy, sx};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      board.note_position(sx, sy, sz);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      burst_left = 0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   // write all registers back to back, plus one write to an unused index
   task automatic program_receiver(logic [23:0] x, y, z, logic [15:0] lat, lon);
      logic [23:0] vals[6];
      vals = '{x, y, z, {{8{lat[15]}}, lat}, {{8{lon[15]}}, lon}, 24'($urandom)};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1;
         csr_index <= (i == 5) ? CSR_UNUSED : CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         board.set_reg((i == 5) ? CSR_UNUSED : CSR_IDX_W'(i), vals[i]);
         @(posedge clock);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic logic [SAT_W-1:0] near(logic [RCV_W-1:0] r);
      int k;
      k = $urandom_range(0, 20);
      return SAT_W'(signed'(r)) + SAT_W'($urandom_range(0, 1 << k)) - SAT_W'(1 << (k / 2));
   endfunction

   task automatic send_random();
      logic [SAT_W-1:0] v[3];
      int pick;
      pick = $urandom_range(0, 9);
      for (int j = 0; j < 3; j++) v[j] = SAT_W'($urandom);
      if (pick < 4) begin
         v[0] = near(board.rcv_x); v[1] = near(board.rcv_y); v[2] = near(board.rcv_z);
      end else if (pick == 4) begin
         v[0] = SAT_W'(signed'(board.rcv_x));
         v[1] = SAT_W'(signed'(board.rcv_y));
         v[2] = SAT_W'(signed'(board.rcv_z));
         v[$urandom_range(0, 2)] = near(board.rcv_x);
      end else if (pick == 5) begin
         for (int j = 0; j < 3; j++)
            v[j] = $urandom_range(0, 1) ? {1'b0, {(SAT_W-1){1'b1}}} : {1'b1, {(SAT_W-1){1'b0}}};
      end
      send_position(v[0], v[1], v[2]);
   endtask

   initial begin
      logic [SAT_W-1:0] pmax, nmin;
      logic [15:0] lat;
      pmax = {1'b0, {(SAT_W-1){1'b1}}};
      nmin = {1'b1, {(SAT_W-1){1'b0}}};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: receiver at the origin, zero latitude and longitude
      send_position(0, 0, 0);
      send_position(26'd1000, 0, 0);
      send_position(-26'sd1000, 0, 0);
      send_position(0, 26'd500, 0);
      send_position(0, 0, 26'd500);
      send_position(pmax, pmax, pmax);
      send_position(nmin, nmin, nmin);
      send_position(pmax, nmin, 26'd1);
      wait_idle();

      program_receiver(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h4000, 16'h8000);
      send_position(26'h07FFFFF, 26'h07FFFFF, 26'h07FFFFF);
      send_position(pmax, pmax, pmax);
      send_position(nmin, nmin, nmin);
      send_position(26'h07FFFFF, 26'h07FFFFF, 26'h0800000);
      send_position(nmin, pmax, 0);
      wait_idle();

      program_receiver(24'h800000, 24'h800000, 24'h800000, 16'hC000, 16'h7FFF);
      send_position(26'h3800000, 26'h3800000, 26'h3800000);
      send_position(pmax, pmax, pmax);
      send_position(nmin, nmin, nmin);
      send_position(0, nmin, pmax);
      wait_idle();

      // latitude past a quarter turn is taken as it stands
      program_receiver(24'h123456, 24'hFEDCBA, 24'h0F0F0F, 16'h7FFF, 16'h0001);
      send_position(pmax, 0, nmin);
      send_position(26'h0123456, 26'h3FEDCBA, 26'h00F0F0F);
      send_position(26'h1555555, 26'h2AAAAAA, 26'h1555555);
      wait_idle();

      for (int ph = 0; ph < 5; ph++) begin
         lat = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
         program_receiver(24'($urandom), 24'($urandom), 24'($urandom), lat, 16'($urandom));
         for (int k = 0; k < 120; k++) begin
            if (ph == 2 && k == 60) wait_idle();
            send_random();
         end
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
hdl/ecef_ae_pkg.sv
hdl/ecef_ae_ctrl.sv
hdl/ecef_ae_rot.sv
hdl/ecef_ae_vec.sv
hdl/ecef_to_azimuth_elevation.sv
dv/tb.sv
